FILE: rtl/core/circular_list_engine_top_macros.svh
`ifndef CIRCULAR_LIST_ENGINE_TOP_MACROS_SVH
`define CIRCULAR_LIST_ENGINE_TOP_MACROS_SVH

// same-cycle implication, off while reset is held
`define CLE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define CLE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cle_pkg.sv
`default_nettype none

package cle_pkg;

    localparam int unsigned CAPACITY_DEF   = 16;
    localparam int unsigned VALUE_BITS_DEF = 32;

    // fixed field widths of the item ports
    localparam int unsigned FUNC_W      = 3;
    localparam int unsigned IN_VALUE_W  = 32;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned OUT_VALUE_W = 32;
    localparam int unsigned POS_W       = 4;
    localparam int unsigned COUNT_W     = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_HEAD  = 3'd0,
        FN_INS_TAIL  = 3'd1,
        FN_REM_HEAD  = 3'd2,
        FN_REM_TAIL  = 3'd3,
        FN_SEARCH    = 3'd4,
        FN_REM_VALUE = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } state_t;

    // one-cycle commands broadcast to every cell
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_PUSH_HEAD,
        CMD_PUSH_TAIL,
        CMD_POP_HEAD
    } cell_cmd_t;

    typedef enum logic [1:0] {
        PRB_SEARCH,
        PRB_REM_TAIL,
        PRB_REM_VALUE
    } probe_kind_t;

    // control part of the probe that travels down the chain
    typedef struct packed {
        logic        valid;
        probe_kind_t kind;
        logic        found;
    } probe_t;

endpackage

`default_nettype wire

FILE: rtl/core/cle_cell.sv
`default_nettype none

module cle_cell #(
    parameter int unsigned CAPACITY   = cle_pkg::CAPACITY_DEF,
    parameter int unsigned VALUE_BITS = cle_pkg::VALUE_BITS_DEF,
    parameter int unsigned INDEX      = 0,
    localparam int unsigned IDX_W     = $clog2(CAPACITY)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire cle_pkg::cell_cmd_t           cmd,
    input  wire logic signed [VALUE_BITS-1:0] query,
    input  wire logic signed [VALUE_BITS-1:0] left_value,
    input  wire logic                         left_valid,
    input  wire logic signed [VALUE_BITS-1:0] right_value,
    input  wire logic                         right_valid,
    input  wire logic                         right_give,
    output logic signed [VALUE_BITS-1:0]      cell_value,
    output logic                              cell_valid,
    output logic                              give,
    input  wire cle_pkg::probe_t              probe_in,
    input  wire logic [IDX_W-1:0]             pos_in,
    input  wire logic signed [VALUE_BITS-1:0] tval_in,
    output cle_pkg::probe_t                   probe_out,
    output logic [IDX_W-1:0]                  pos_out,
    output logic signed [VALUE_BITS-1:0]      tval_out
);
    import cle_pkg::*;

    logic signed [VALUE_BITS-1:0] value_reg, value_next;
    logic                         valid_reg, valid_next;
    probe_t                       pr_reg;
    logic [IDX_W-1:0]             pos_reg;
    logic signed [VALUE_BITS-1:0] tval_reg;

    logic is_lookup, is_rem_value, is_rem_tail, hit;

    assign is_lookup    = pr_reg.valid && (pr_reg.kind == PRB_SEARCH ||
                                           pr_reg.kind == PRB_REM_VALUE);
    assign is_rem_value = pr_reg.valid && pr_reg.kind == PRB_REM_VALUE;
    assign is_rem_tail  = pr_reg.valid && pr_reg.kind == PRB_REM_TAIL;
    assign hit          = is_lookup && valid_reg && !pr_reg.found && value_reg == query;

    // entries behind a removed one move one cell toward the head
    assign give = is_rem_value && pr_reg.found;

    always_comb begin
        probe_out       = pr_reg;
        probe_out.found = pr_reg.found | hit;
    end

    assign pos_out    = hit ? IDX_W'(INDEX) : pos_reg;
    assign tval_out   = (is_rem_tail && valid_reg) ? value_reg : tval_reg;
    assign cell_value = value_reg;
    assign cell_valid = valid_reg;

    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        unique case (cmd)
            CMD_HOLD: begin
            end
            CMD_PUSH_HEAD: begin
                value_next = left_value;
                valid_next = left_valid;
            end
            CMD_PUSH_TAIL: begin
                if (!valid_reg && left_valid) begin
                    value_next = query;
                    valid_next = 1'b1;
                end
            end
            CMD_POP_HEAD: begin
                value_next = right_value;
                valid_next = right_valid;
            end
            default: begin
            end
        endcase
        if (right_give) begin
            value_next = right_value;
            valid_next = right_valid;
        end
        // matched cell or a cell that moved forward empties itself
        if (give || (is_rem_value && hit)) begin
            valid_next = 1'b0;
        end
        // last occupied cell drops out on tail removal
        if (is_rem_tail && valid_reg && !right_valid) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pr_reg    <= '0;
        end else begin
            valid_reg <= valid_next;
            pr_reg    <= probe_in;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        pos_reg   <= pos_in;
        tval_reg  <= tval_in;
    end

endmodule

`default_nettype wire

FILE: rtl/core/circular_list_engine_top.sv
// insert and head removal change the cells as the item is taken and then hold the result;
// search, tail removal and value removal first walk a probe through the cell chain
// one cell per cycle; a new item is taken only once the result of the last one has
// been loaded into the output register, which waits while m_valid is held without m_ready
// reset: synchronous active-low aresetn empties the list and drops any pending result
`default_nettype none

module circular_list_engine_top #(
    parameter int unsigned CAPACITY   = cle_pkg::CAPACITY_DEF,
    parameter int unsigned VALUE_BITS = cle_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [cle_pkg::FUNC_W-1:0]            s_func,
    input  wire logic signed [cle_pkg::IN_VALUE_W-1:0] s_value,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [cle_pkg::STATUS_W-1:0]               m_status,
    output logic signed [cle_pkg::OUT_VALUE_W-1:0]     m_out_value,
    output logic [cle_pkg::POS_W-1:0]                  m_position,
    output logic [cle_pkg::COUNT_W-1:0]                m_count
);
    import cle_pkg::*;

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;

    // held query value while the probe walks
    logic signed [VALUE_BITS-1:0] query_reg, query_next;
    logic signed [VALUE_BITS-1:0] in_value;
    logic signed [VALUE_BITS-1:0] query;

    // result waiting for the output register
    status_t                       res_status_reg, res_status_next;
    logic signed [OUT_VALUE_W-1:0] res_value_reg, res_value_next;
    logic [POS_W-1:0]              res_pos_reg, res_pos_next;

    // output register
    status_t                       m_status_reg, m_status_next;
    logic signed [OUT_VALUE_W-1:0] m_value_reg, m_value_next;
    logic [POS_W-1:0]              m_pos_reg, m_pos_next;
    logic [COUNT_W-1:0]            m_count_reg, m_count_next;

    // cell chain
    cell_cmd_t                    cmd;
    probe_t                       inject;
    logic signed [VALUE_BITS-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]          cell_vld;
    logic [CAPACITY-1:0]          cell_give;
    probe_t                       chain_probe [CAPACITY+1];
    logic [IDX_W-1:0]             chain_pos   [CAPACITY+1];
    logic signed [VALUE_BITS-1:0] chain_tval  [CAPACITY+1];
    probe_t                       exit_probe;

    logic list_full, list_empty, out_free;

    // stored width follows VALUE_BITS: truncate or sign-extend the item value
    assign in_value   = VALUE_BITS'(s_value);
    assign query      = (state_reg == S_IDLE) ? in_value : query_reg;
    assign list_full  = count_reg == CNT_W'(CAPACITY);
    assign list_empty = count_reg == '0;
    assign out_free   = !m_valid_reg || m_ready;
    assign exit_probe = chain_probe[CAPACITY];

    assign s_ready     = state_reg == S_IDLE;
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_out_value = m_value_reg;
    assign m_position  = m_pos_reg;
    assign m_count     = m_count_reg;

    // probe enters at the head cell with nothing found yet
    assign chain_probe[0] = inject;
    assign chain_pos[0]   = '0;
    assign chain_tval[0]  = '0;

    // cell i holds list position i; outside a walk the occupied cells are packed from cell 0
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_BITS-1:0] lval, rval;
        logic                         lvld, rvld, rgive;

        if (i == 0) begin : g_first
            // head cell takes the new value on insert at head
            assign lval = query;
            assign lvld = 1'b1;
        end else begin : g_inner_l
            assign lval = cell_val[i-1];
            assign lvld = cell_vld[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign rval  = '0;
            assign rvld  = 1'b0;
            assign rgive = 1'b0;
        end else begin : g_inner_r
            assign rval  = cell_val[i+1];
            assign rvld  = cell_vld[i+1];
            assign rgive = cell_give[i+1];
        end

        cle_cell #(
            .CAPACITY   (CAPACITY),
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cmd),
            .query       (query),
            .left_value  (lval),
            .left_valid  (lvld),
            .right_value (rval),
            .right_valid (rvld),
            .right_give  (rgive),
            .cell_value  (cell_val[i]),
            .cell_valid  (cell_vld[i]),
            .give        (cell_give[i]),
            .probe_in    (chain_probe[i]),
            .pos_in      (chain_pos[i]),
            .tval_in     (chain_tval[i]),
            .probe_out   (chain_probe[i+1]),
            .pos_out     (chain_pos[i+1]),
            .tval_out    (chain_tval[i+1])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = inject.valid ? S_WALK : S_HOLD;
                end
            end
            S_WALK: begin
                if (exit_probe.valid) begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd             = CMD_HOLD;
        inject          = '0;
        count_next      = count_reg;
        query_next      = query_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_pos_next      = m_pos_reg;
        m_count_next    = m_count_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    query_next      = in_value;
                    res_status_next = STAT_OK;
                    res_value_next  = '0;
                    res_pos_next    = '0;
                    unique case (func_t'(s_func))
                        FN_INS_HEAD, FN_INS_TAIL: begin
                            if (list_full) begin
                                res_status_next = STAT_FULL;
                            end else begin
                                cmd = (func_t'(s_func) == FN_INS_HEAD) ? CMD_PUSH_HEAD
                                                                       : CMD_PUSH_TAIL;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_REM_HEAD: begin
                            if (list_empty) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                cmd            = CMD_POP_HEAD;
                                res_value_next = OUT_VALUE_W'(cell_val[0]);
                                count_next     = count_reg - CNT_W'(1);
                            end
                        end
                        FN_REM_TAIL: begin
                            if (list_empty) begin
                                res_status_next = STAT_EMPTY;
                            end else begin
                                inject.valid = 1'b1;
                                inject.kind  = PRB_REM_TAIL;
                            end
                        end
                        FN_SEARCH: begin
                            inject.valid = 1'b1;
                            inject.kind  = PRB_SEARCH;
                        end
                        FN_REM_VALUE: begin
                            inject.valid = 1'b1;
                            inject.kind  = PRB_REM_VALUE;
                        end
                        default: begin
                            // unused codes: plain ok with the current count
                        end
                    endcase
                end
            end
            S_WALK: begin
                // probe has left the last cell, chain is settled after this edge
                if (exit_probe.valid) begin
                    unique case (exit_probe.kind)
                        PRB_REM_TAIL: begin
                            res_value_next = OUT_VALUE_W'(chain_tval[CAPACITY]);
                            count_next     = count_reg - CNT_W'(1);
                        end
                        PRB_SEARCH: begin
                            if (exit_probe.found) begin
                                res_pos_next = POS_W'(chain_pos[CAPACITY]);
                            end else begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                        end
                        PRB_REM_VALUE: begin
                            if (exit_probe.found) begin
                                count_next = count_reg - CNT_W'(1);
                            end else begin
                                res_status_next = STAT_NOT_FOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HOLD: begin
            end
            default: begin
            end
        endcase

        // output register: drain, then refill from the pending result
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (state_reg == S_HOLD && out_free) begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_value_next  = res_value_reg;
            m_pos_next    = res_pos_reg;
            m_count_next  = COUNT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        query_reg      <= query_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_pos_reg    <= res_pos_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_pos_reg      <= m_pos_next;
        m_count_reg    <= m_count_next;
    end

`include "circular_list_engine_top_macros.svh"

    // outside a walk the occupied cells form one run starting at the head cell
    `CLE_ASSERT_NOW(a_cells_packed, aclk, aresetn, state_reg != S_WALK, (cell_vld & (cell_vld + CAPACITY'(1))) == '0, "occupied cells not packed from head")
    // outside a walk the element count matches the occupied cells
    `CLE_ASSERT_NOW(a_count_match, aclk, aresetn, state_reg != S_WALK, $countones(cell_vld) == count_reg, "element count out of step with cells")
    // a probe leaving the chain closes the walk
    `CLE_ASSERT_NEXT(a_walk_closes, aclk, aresetn, exit_probe.valid, state_reg == S_HOLD, "probe exit did not end the walk")

endmodule

`default_nettype wire
